// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared constants for the scalar Kalman filter: gain format, register
// indexes and noise defaults.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Gain is unsigned Q0.16; 1.0 needs one extra bit.
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;

    // Step counter for the divider and multiplier loops.
    localparam int STEP_W = $clog2(GAIN_W);

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASUREMENT_NOISE = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_ESTIMATE  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_VARIANCE  = 4'd3;

    // Integer parts of the default noise covariances.
    localparam logic [63:0] Q_DEFAULT_INT = 64'd200;
    localparam logic [63:0] R_DEFAULT_INT = 64'd500;

endpackage

// ----- rtl/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-channel Kalman filter with unit prediction and observation
// coefficients, fixed-point state, and a shared iterative datapath.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Beat contents
//  -------  ---------  --------------------  ------------------------------
//  in       sink       in_valid / in_stall   measurement
//  out      source     out_valid / out_stall estimate, variance
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An accepted measurement is predicted, divided for the gain and then
//  corrected; the block takes no new measurement until it is back in idle.
//  The gain comes from the 17-step restoring divider, and the two 17-step
//  shift-add multiplies share one accumulator.
//  A result waits in the output register while out_stall is high; the block
//  still takes a new measurement meanwhile and holds its own result at the
//  last step until the output register frees up.
//  Reset loads the default noise values and clears estimate and variance.
//
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int SAMPLE_WIDTH  = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] measurement,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             estimate,
    output logic        [31:0]             variance,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic        [CFG_INDEX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0]   cfg_data
);

    // Difference width covers both the scaled sample and the 32-bit estimate.
    localparam int ZW  = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int DW  = ((ZW > 32) ? ZW : 32) + 1;
    localparam int PW  = DW + GAIN_W;
    localparam int RW  = PW - GAIN_BITS + 1;
    localparam int NXW = RW + 2;

    localparam logic [63:0] Q_WIDE = Q_DEFAULT_INT << FRACTION_BITS;
    localparam logic [63:0] R_WIDE = R_DEFAULT_INT << FRACTION_BITS;
    localparam logic [31:0] Q_RST  = (Q_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : Q_WIDE[31:0];
    localparam logic [31:0] R_RST  = (R_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : R_WIDE[31:0];

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GAIN_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_DIV_SETUP,
        S_DIV,
        S_MUL_EST,
        S_RND_EST,
        S_UPD_EST,
        S_MUL_VAR,
        S_RND_VAR,
        S_UPD_VAR
    } state_t;

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [SAMPLE_WIDTH-1:0]  z_reg, z_next;
    logic [31:0]              p_reg, p_next;
    logic [32:0]              denom_reg, denom_next;
    logic [32:0]              rem_reg, rem_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic [GAIN_W-1:0]        mbits_reg, mbits_next;
    logic [DW-1:0]            mcand_reg, mcand_next;
    logic [PW-1:0]            acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic [31:0]              q_reg, q_next;
    logic [31:0]              r_reg, r_next;
    logic [31:0]              x_reg, x_next;
    logic [31:0]              var_reg, var_next;
    logic [31:0]              est_out_reg, est_out_next;
    logic [31:0]              var_out_reg, var_out_next;
    logic                     out_valid_reg, out_valid_next;

    // Datapath terms.
    logic [32:0]              pred_sum;
    logic [31:0]              pred_p;
    logic [DW-1:0]            zq;
    logic [DW-1:0]            xe;
    logic [DW-1:0]            diff;
    logic [DW-1:0]            mag;
    logic                     bit_in;
    logic [33:0]              rem_sh;
    logic [34:0]              rem_sub;
    logic                     q_bit;
    logic [GAIN_W-1:0]        gain_shift;
    logic [PW-1:0]            mul_sum;
    logic [PW:0]              round_sum;
    logic [PW-1:0]            acc_up;
    logic [PW-1:0]            acc_down;
    logic [NXW-1:0]           x_wide;
    logic [NXW-1:0]           q_wide;
    logic [NXW-1:0]           nx;
    logic                     nx_ovf;
    logic [31:0]              nx_sat;
    logic                     out_free;

    always_comb
    begin
        pred_sum = {1'b0, var_reg} + {1'b0, q_reg};
        pred_p   = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];

        zq   = {{(DW - SAMPLE_WIDTH){z_reg[SAMPLE_WIDTH-1]}}, z_reg} << FRACTION_BITS;
        xe   = {{(DW - 32){x_reg[31]}}, x_reg};
        diff = zq - xe;
        mag  = diff[DW-1] ? (~diff + DW'(1)) : diff;

        // One restoring division step; the only nonzero dividend bit below
        // the starting remainder is the low bit of p.
        bit_in     = (step_reg == '0) ? p_reg[0] : 1'b0;
        rem_sh     = {rem_reg, bit_in};
        rem_sub    = {1'b0, rem_sh} - {2'b00, denom_reg};
        q_bit      = !rem_sub[34] && (denom_reg != '0);
        gain_shift = {gain_reg[GAIN_W-2:0], q_bit};

        // Shift-add multiply, multiplier bits taken from the top.
        mul_sum = {acc_reg[PW-2:0], 1'b0}
                  + (mbits_reg[GAIN_W-1] ? {{(PW - DW){1'b0}}, mcand_reg} : '0);

        round_sum = {1'b0, acc_reg} + {{(PW + 1 - GAIN_BITS){1'b0}}, {GAIN_BITS{1'b1}}};
        acc_up    = {{(GAIN_BITS - 1){1'b0}}, round_sum[PW:GAIN_BITS]};
        acc_down  = {{GAIN_BITS{1'b0}}, acc_reg[PW-1:GAIN_BITS]};

        x_wide = {{(NXW - 32){x_reg[31]}}, x_reg};
        q_wide = {2'b00, acc_reg[RW-1:0]};
        nx     = neg_reg ? (x_wide - q_wide) : (x_wide + q_wide);
        nx_ovf = !((&nx[NXW-1:31]) || !(|nx[NXW-1:31]));
        nx_sat = nx_ovf ? (nx[NXW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : nx[31:0];

        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        z_next         = z_reg;
        p_next         = p_reg;
        denom_next     = denom_reg;
        rem_next       = rem_reg;
        gain_next      = gain_reg;
        mbits_next     = mbits_reg;
        mcand_next     = mcand_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        x_next         = x_reg;
        var_next       = var_reg;
        est_out_next   = est_out_reg;
        var_out_next   = var_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROCESS_NOISE:     q_next = cfg_data;
                CFG_MEASUREMENT_NOISE: r_next = cfg_data;
                CFG_INITIAL_ESTIMATE:  x_next = cfg_data;
                CFG_INITIAL_VARIANCE:  var_next = cfg_data;
                default:               ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    z_next     = measurement;
                    state_next = S_PRED;
                end
            end

            S_PRED:
            begin
                p_next     = pred_p;
                neg_next   = diff[DW-1];
                mcand_next = mag;
                state_next = S_DIV_SETUP;
            end

            S_DIV_SETUP:
            begin
                denom_next = {1'b0, p_reg} + {1'b0, r_reg};
                rem_next   = {2'b00, p_reg[31:1]};
                gain_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                rem_next  = q_bit ? rem_sub[32:0] : rem_sh[32:0];
                gain_next = gain_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    mbits_next = gain_shift;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = S_MUL_EST;
                end
            end

            S_MUL_EST:
            begin
                acc_next   = mul_sum;
                mbits_next = {mbits_reg[GAIN_W-2:0], 1'b0};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_RND_EST;
                end
            end

            S_RND_EST:
            begin
                // A negative step is floored, so its magnitude rounds up.
                acc_next   = neg_reg ? acc_up : acc_down;
                state_next = S_UPD_EST;
            end

            S_UPD_EST:
            begin
                x_next     = nx_sat;
                mcand_next = {{(DW - 32){1'b0}}, p_reg};
                mbits_next = gain_reg;
                acc_next   = '0;
                step_next  = '0;
                state_next = S_MUL_VAR;
            end

            S_MUL_VAR:
            begin
                acc_next   = mul_sum;
                mbits_next = {mbits_reg[GAIN_W-2:0], 1'b0};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_RND_VAR;
                end
            end

            S_RND_VAR:
            begin
                // p * (1 - k) truncated equals p minus p * k rounded up.
                acc_next   = acc_up;
                state_next = S_UPD_VAR;
            end

            S_UPD_VAR:
            begin
                if (out_free)
                begin
                    var_next       = p_reg - acc_reg[31:0];
                    est_out_next   = x_reg;
                    var_out_next   = p_reg - acc_reg[31:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            z_reg         <= '0;
            p_reg         <= '0;
            denom_reg     <= '0;
            rem_reg       <= '0;
            gain_reg      <= '0;
            mbits_reg     <= '0;
            mcand_reg     <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            q_reg         <= Q_RST;
            r_reg         <= R_RST;
            x_reg         <= '0;
            var_reg       <= '0;
            est_out_reg   <= '0;
            var_out_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            z_reg         <= z_next;
            p_reg         <= p_next;
            denom_reg     <= denom_next;
            rem_reg       <= rem_next;
            gain_reg      <= gain_next;
            mbits_reg     <= mbits_next;
            mcand_reg     <= mcand_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            x_reg         <= x_next;
            var_reg       <= var_next;
            est_out_reg   <= est_out_next;
            var_out_reg   <= var_out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign estimate  = est_out_reg;
    assign variance  = var_out_reg;

endmodule

// ----- sim/scalar_kalman_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives measurement beats through the filter, predicts each estimate and
// variance from a private copy of the filter state, and checks every output
// beat in order. Noise settings are rewritten between idle phases, the
// corner cases are covered first, and the random part varies both
// handshakes and includes one long output hold-off.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_tb;
    import skf_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_W    = 16;
    localparam int LATENCY     = 58;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int GROUPS      = 6;
    localparam int GROUP_ITEMS = 72;
    localparam int MAX_REPORTS = 10;

    // No register lives at this index; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 4'd15;

    typedef struct packed {
        logic signed [31:0] estimate;
        logic        [31:0] variance;
    } filter_out_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_W-1:0]    measurement = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [31:0]            estimate;
    logic        [31:0]            variance;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic        [CFG_INDEX_W-1:0] cfg_index = '0;
    logic        [CFG_DATA_W-1:0]  cfg_data = '0;

    scalar_kalman_filter #(
        .FRACTION_BITS(FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .measurement(measurement),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .estimate   (estimate),
        .variance   (variance),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Private copy of the filter registers and state.
    logic        [31:0] q_cov;
    logic        [31:0] r_cov;
    logic signed [31:0] model_estimate;
    logic        [31:0] model_variance;

    logic [SAMPLE_W-1:0] pending_samples[$];
    filter_out_t         predicted_outputs[$];
    filter_out_t         next_predicted;

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int settings_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 17;
    int recv_idle_pct  = 45;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // One measurement update: predict, form the gain, correct estimate and variance.
    function automatic filter_out_t kalman_update(input logic signed [SAMPLE_W-1:0] z);
        logic [32:0]         p_sum;
        logic [31:0]         p;
        logic [63:0]         denom;
        logic [63:0]         numer;
        logic [63:0]         gain;
        logic [63:0]         mag;
        logic [63:0]         prod;
        longint              zq;
        longint              diff;
        longint              delta;
        longint              nx;
        filter_out_t         res;
        p_sum = {1'b0, model_variance} + {1'b0, q_cov};
        p     = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        denom = 64'(p) + 64'(r_cov);
        numer = 64'(p) << GAIN_BITS;
        gain  = (denom != 0) ? numer / denom : 64'd0;

        zq   = longint'(z) * (longint'(1) <<< FRAC_BITS);
        diff = zq - longint'(model_estimate);
        // Negative corrections round toward minus infinity.
        if (diff < 0)
        begin
            mag   = -diff;
            prod  = mag * gain;
            delta = -$signed((prod + ((64'd1 << GAIN_BITS) - 64'd1)) >> GAIN_BITS);
        end
        else
        begin
            mag   = diff;
            prod  = mag * gain;
            delta = $signed(prod >> GAIN_BITS);
        end
        nx = longint'(model_estimate) + delta;
        if (nx > longint'(32'sh7FFF_FFFF))
            nx = longint'(32'sh7FFF_FFFF);
        if (nx < longint'(32'sh8000_0000))
            nx = longint'(32'sh8000_0000);
        model_estimate = nx[31:0];

        prod           = (64'(p) * ((64'd1 << GAIN_BITS) - gain)) >> GAIN_BITS;
        model_variance = prod[31:0];

        res.estimate = model_estimate;
        res.variance = model_variance;
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_measurement();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(200) - 100);
            3:       return $urandom_range(1) ? 16'sd0 : -16'sd1;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_covariance();
        case ($urandom_range(6))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(32'h0010_0000);
            3,
            4:       return $urandom_range(32'h0400_0000);
            default: return $urandom();
        endcase
    endfunction

    // Call right after a rising edge; returns after the write beat is taken.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PROCESS_NOISE:     q_cov = data;
            CFG_MEASUREMENT_NOISE: r_cov = data;
            CFG_INITIAL_ESTIMATE:  model_estimate = data;
            CFG_INITIAL_VARIANCE:  model_variance = data;
            default: ;
        endcase
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value);
        pending_samples.push_back(value);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch in %s of output %0d: expected %h, got %h",
                     what, results_seen, want, got);
    endtask

    // Measurement driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            measurement <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted_outputs.push_back(kalman_update(measurement));
                items_accepted <= items_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    measurement <= pending_samples.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure, with one long hold-off that fills the filter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_accepted >= HOLD_AFTER)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Output checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (predicted_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Output beat with nothing pending: estimate %h, variance %h",
                             estimate, variance);
            end
            else
            begin
                next_predicted = predicted_outputs.pop_front();
                if (estimate !== next_predicted.estimate)
                    note_mismatch("estimate", next_predicted.estimate, estimate);
                if (variance !== next_predicted.variance)
                    note_mismatch("variance", next_predicted.variance, variance);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d of %0d outputs seen",
                     cycle_count, results_seen, items_queued);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        q_cov          = 32'(Q_DEFAULT_INT << FRAC_BITS);
        r_cov          = 32'(R_DEFAULT_INT << FRAC_BITS);
        model_estimate = '0;
        model_variance = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults with the sample extremes.
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sd0);
        queue_sample(-16'sd1);
        queue_sample(16'sd1);
        wait_drained();

        // Both noise terms and the variance at zero leave the gain at zero.
        write_register(CFG_PROCESS_NOISE, 32'd0);
        write_register(CFG_MEASUREMENT_NOISE, 32'd0);
        write_register(CFG_INITIAL_VARIANCE, 32'd0);
        queue_sample(16'sd1234);
        wait_drained();

        // Zero measurement noise gives unit gain; swing the estimate end to end.
        write_register(CFG_PROCESS_NOISE, 32'h0001_0000);
        write_register(CFG_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh7FFF);
        wait_drained();
        write_register(CFG_INITIAL_ESTIMATE, 32'h8000_0000);
        queue_sample(16'sh7FFF);
        wait_drained();

        // Predicted variance saturates.
        write_register(CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_register(CFG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
        write_register(CFG_INITIAL_VARIANCE, 32'hFFFF_FFFF);
        queue_sample(16'sh8000);
        queue_sample(-16'sd5);
        wait_drained();

        // A write past the last register must be ignored.
        write_register(CFG_UNUSED_INDEX, $urandom());
        queue_sample(16'sh7FFF);
        wait_drained();

        for (int g = 0; g < GROUPS; g++)
        begin
            case (g / 2)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 45;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_register(CFG_PROCESS_NOISE, pick_covariance());
            write_register(CFG_MEASUREMENT_NOISE, pick_covariance());
            if (g == 0 || $urandom_range(1))
                write_register(CFG_INITIAL_ESTIMATE, $urandom());
            if (g == 0 || $urandom_range(1))
                write_register(CFG_INITIAL_VARIANCE, pick_covariance());
            settings_count++;
            for (int i = 0; i < GROUP_ITEMS; i++)
                queue_sample(pick_measurement());
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge clk);
        mismatch_count += predicted_outputs.size();

        $display("Checked %0d filter outputs: directed corner cases plus %0d random noise settings,",
                 results_seen, settings_count);
        $display("with random gaps on both channels and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/skf_pkg.sv
rtl/scalar_kalman_filter.sv
sim/scalar_kalman_filter_tb.sv
